// ===== rtl/rv32i_subset_core_top_macros.svh =====
// Assertion helpers for the RTL of the rv32i subset core.
`ifndef RV32I_SUBSET_CORE_TOP_MACROS_SVH
`define RV32I_SUBSET_CORE_TOP_MACROS_SVH

// Same-cycle implication, checked on aclk, off while reset is low
`define RVSC_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, off while reset is low
`define RVSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rvsc_pkg.sv =====
`default_nettype none

package rvsc_pkg;

    // Command codes carried on s_tuser
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    // Major opcodes
    localparam logic [6:0] OP_IMM    = 7'd19;
    localparam logic [6:0] OP_JALR   = 7'd103;
    localparam logic [6:0] OP_REG    = 7'd51;
    localparam logic [6:0] OP_LUI    = 7'd55;
    localparam logic [6:0] OP_LOAD   = 7'd3;
    localparam logic [6:0] OP_STORE  = 7'd35;
    localparam logic [6:0] OP_SYSTEM = 7'd115;

    // funct3 / funct7 / funct12 values used by the subset
    localparam logic [2:0]  F3_ADD      = 3'd0;
    localparam logic [2:0]  F3_BYTE     = 3'd0;
    localparam logic [2:0]  F3_WORD     = 3'd2;
    localparam logic [2:0]  F3_BYTEU    = 3'd4;
    localparam logic [6:0]  F7_ADD      = 7'd0;
    localparam logic [11:0] F12_EBREAK  = 12'd1;

    // Byte positions within a word
    localparam logic [1:0] BYTE_FIRST = 2'd0;
    localparam logic [1:0] BYTE_LAST  = 2'd3;

    typedef struct packed {
        logic        start;
        logic [31:0] addr;
    } wrap_req_t;

    function automatic logic [31:0] imm_i(input logic [31:0] ins);
        return {{20{ins[31]}}, ins[31:20]};
    endfunction

    function automatic logic [31:0] imm_s(input logic [31:0] ins);
        return {{20{ins[31]}}, ins[31:25], ins[11:7]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rvsc_addr_wrap.sv =====
`default_nettype none

// Reduces a 32-bit byte address modulo MEM_BYTES.
// Power of two: a mask. Otherwise in registered steps: a reciprocal
// multiply estimates the quotient, a multiply and subtract forms the
// remainder, and one compare and subtract corrects the estimate.
module rvsc_addr_wrap
    import rvsc_pkg::*;
#(
    parameter int MEM_BYTES = 1024,
    localparam int AW = $clog2(MEM_BYTES)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire wrap_req_t     req,
    output logic               done,
    output logic [AW-1:0]      result
);

    localparam bit          Pow2  = (MEM_BYTES & (MEM_BYTES - 1)) == 0;
    localparam logic [32:0] Span  = 33'h1_0000_0000;
    localparam logic [31:0] Recip = 32'(Span / 33'(MEM_BYTES));
    localparam logic [31:0] ModW  = 32'(MEM_BYTES);
    localparam logic [AW:0] ModR  = (AW + 1)'(MEM_BYTES);

    logic          done_reg;
    logic          est_vld_reg;
    logic          sub_vld_reg;
    logic [31:0]   val_reg;
    logic [63:0]   prod_reg;
    logic [AW:0]   diff_reg;
    logic [AW-1:0] rem_reg;
    logic [31:0]   quot;
    logic [31:0]   diff_full;
    logic [AW:0]   diff_fix;

    // quotient estimate is at most one low, so the remainder stays below 2 x MEM_BYTES
    assign quot      = prod_reg[63:32];
    assign diff_full = val_reg - quot * ModW;
    assign diff_fix  = diff_reg - ModR;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= 1'b0;
            est_vld_reg <= 1'b0;
            sub_vld_reg <= 1'b0;
        end else begin
            done_reg    <= 1'b0;
            est_vld_reg <= 1'b0;
            sub_vld_reg <= est_vld_reg;
            if (req.start) begin
                if (Pow2) begin
                    rem_reg  <= req.addr[AW-1:0];
                    done_reg <= 1'b1;
                end else begin
                    val_reg     <= req.addr;
                    prod_reg    <= {32'd0, req.addr} * {32'd0, Recip};
                    est_vld_reg <= 1'b1;
                end
            end
            if (est_vld_reg) begin
                diff_reg <= diff_full[AW:0];
            end
            if (sub_vld_reg) begin
                rem_reg  <= (diff_reg >= ModR) ? diff_fix[AW-1:0] : diff_reg[AW-1:0];
                done_reg <= 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/rv32i_subset_core_top.sv =====
// Channel  Dir  Beat contents
// -------  ---  ------------------------------------------------------------
// s_       in   tuser: command; tdata: mem_address, mem_byte
// m_       out  tdata: halted, read_byte, executed_pc, instruction,
//                      dest_valid, dest_index, dest_value, next_pc
//
// One beat at a time. A fetched or loaded byte is wrapped, then read back; a stored
// byte is wrapped and written. The wrap is longer when MEM_BYTES is not a power of two.
// An execute while halted or an unknown command goes straight to the result.
// Reset: pc, halt flag and register valid bits clear.
// A waiting result stalls nothing until the next one is ready to leave.
`default_nettype none

`include "rv32i_subset_core_top_macros.svh"

module rv32i_subset_core_top
    import rvsc_pkg::*;
#(
    parameter int MEM_BYTES = 1024
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // mem_address[9:0], mem_byte[17:10], zero
    input  wire logic [1:0]   s_tuser,   // command[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata    // halted[0], read_byte[8:1],
                                         // executed_pc[40:9], instruction[72:41],
                                         // dest_valid[73], dest_index[78:74],
                                         // dest_value[110:79], next_pc[142:111]
);

    localparam int AW = $clog2(MEM_BYTES);

    typedef enum logic [2:0] {
        S_IDLE, S_WRAP, S_MEM, S_REGRD, S_EXEC, S_FINISH, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_CMD, PH_FETCH, PH_LOAD, PH_STORE
    } phase_t;

    state_t        state_reg;
    phase_t        phase_reg;
    logic [1:0]    cmd_reg;
    logic [7:0]    byte_reg;
    logic [31:0]   base_reg;
    logic [1:0]    idx_reg;
    logic [1:0]    last_reg;
    logic [31:0]   ins_reg;
    logic [31:0]   wv_reg;
    logic          wr_reg;
    logic [31:0]   npc_reg;
    logic [31:0]   pc_reg;
    logic          halt_reg;
    logic [7:0]    rbyte_reg;
    logic [31:0]   epc_reg;
    logic          dvalid_reg;
    logic [4:0]    didx_reg;
    logic [31:0]   dval_reg;
    logic [31:0]   store_reg;
    logic          wrap_start_reg;
    logic [31:0]   wrap_addr_reg;
    logic [31:0]   rf_valid_reg;
    logic          m_tvalid_reg;
    logic [143:0]  m_tdata_reg;

    // address wrap unit
    wrap_req_t     wrap_req;
    logic          wrap_done;
    logic [AW-1:0] wrap_result;

    assign wrap_req.start = wrap_start_reg;
    assign wrap_req.addr  = wrap_addr_reg;

    rvsc_addr_wrap #(
        .MEM_BYTES (MEM_BYTES)
    ) u_wrap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (wrap_req),
        .done    (wrap_done),
        .result  (wrap_result)
    );

    // byte memory, one port, registered read
    logic [7:0]    mem_array [MEM_BYTES];
    logic [7:0]    mem_rdata;
    logic          mem_we;
    logic          mem_re;
    logic [7:0]    mem_wdata;
    logic          mem_wr_kind;

    assign mem_wr_kind = (phase_reg == PH_STORE) ||
                         (phase_reg == PH_CMD && cmd_reg == CMD_WRITE);
    assign mem_we    = (state_reg == S_WRAP) && wrap_done && mem_wr_kind;
    assign mem_re    = (state_reg == S_WRAP) && wrap_done && !mem_wr_kind;
    assign mem_wdata = (phase_reg == PH_STORE) ? store_reg[{idx_reg, 3'b000} +: 8] : byte_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_array[wrap_result] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata <= mem_array[wrap_result];
        end
    end

    // register file, two read ports, one write port
    logic [31:0] rf_mem [32];
    logic [31:0] rs1_q;
    logic [31:0] rs2_q;
    logic [4:0]  rs1_idx;
    logic [4:0]  rs2_idx;
    logic [4:0]  rd_idx;
    logic        rf_we;

    assign rs1_idx = ins_reg[19:15];
    assign rs2_idx = ins_reg[24:20];
    assign rd_idx  = ins_reg[11:7];
    assign rf_we   = (state_reg == S_FINISH) && wr_reg && (rd_idx != 5'd0);

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rd_idx] <= wv_reg;
        end
        if (state_reg == S_REGRD) begin
            rs1_q <= rf_mem[rs1_idx];
            rs2_q <= rf_mem[rs2_idx];
        end
    end

    // decode and execute datapath
    logic [31:0] rs1v;
    logic [31:0] rs2v;
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [31:0] sum_i;
    logic [31:0] sum_s;
    logic [31:0] pc4;
    logic        is_addi, is_jalr, is_add, is_lui, is_load, is_store, is_halt_op;

    assign rs1v       = rf_valid_reg[rs1_idx] ? rs1_q : 32'd0;
    assign rs2v       = rf_valid_reg[rs2_idx] ? rs2_q : 32'd0;
    assign op         = ins_reg[6:0];
    assign f3         = ins_reg[14:12];
    assign sum_i      = rs1v + imm_i(ins_reg);
    assign sum_s      = rs1v + imm_s(ins_reg);
    assign pc4        = epc_reg + 32'd4;
    assign is_addi    = (op == OP_IMM) && (f3 == F3_ADD);
    assign is_jalr    = (op == OP_JALR) && (f3 == F3_ADD);
    assign is_add     = (op == OP_REG) && (f3 == F3_ADD) && (ins_reg[31:25] == F7_ADD);
    assign is_lui     = (op == OP_LUI);
    assign is_load    = (op == OP_LOAD) && ((f3 == F3_WORD) || (f3 == F3_BYTEU));
    assign is_store   = (op == OP_STORE) && ((f3 == F3_WORD) || (f3 == F3_BYTE));
    assign is_halt_op = (op == OP_SYSTEM) && (f3 == F3_ADD) && (ins_reg[31:20] == F12_EBREAK);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_CMD;
            pc_reg         <= '0;
            halt_reg       <= 1'b0;
            rf_valid_reg   <= '0;
            wrap_start_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            wrap_start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg    <= s_tuser;
                        byte_reg   <= s_tdata[17:10];
                        rbyte_reg  <= '0;
                        epc_reg    <= '0;
                        ins_reg    <= '0;
                        dvalid_reg <= 1'b0;
                        didx_reg   <= '0;
                        dval_reg   <= '0;
                        wr_reg     <= 1'b0;
                        idx_reg    <= BYTE_FIRST;
                        last_reg   <= BYTE_LAST;
                        unique case (s_tuser)
                            CMD_WRITE, CMD_READ: begin
                                phase_reg      <= PH_CMD;
                                wrap_addr_reg  <= {22'd0, s_tdata[9:0]};
                                wrap_start_reg <= 1'b1;
                                state_reg      <= S_WRAP;
                            end
                            CMD_EXEC: begin
                                epc_reg <= pc_reg;
                                if (halt_reg) begin
                                    state_reg <= S_DONE;
                                end else begin
                                    phase_reg      <= PH_FETCH;
                                    base_reg       <= pc_reg;
                                    wrap_addr_reg  <= pc_reg;
                                    wrap_start_reg <= 1'b1;
                                    state_reg      <= S_WRAP;
                                end
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                // memory access goes out as the wrapped address lands
                S_WRAP: begin
                    if (wrap_done) begin
                        unique case (phase_reg)
                            PH_CMD: begin
                                state_reg <= (cmd_reg == CMD_WRITE) ? S_DONE : S_MEM;
                            end
                            PH_FETCH, PH_LOAD: begin
                                state_reg <= S_MEM;
                            end
                            PH_STORE: begin
                                if (idx_reg == last_reg) begin
                                    state_reg <= S_FINISH;
                                end else begin
                                    idx_reg        <= idx_reg + 1'b1;
                                    wrap_addr_reg  <= base_reg + {30'd0, idx_reg} + 32'd1;
                                    wrap_start_reg <= 1'b1;
                                end
                            end
                        endcase
                    end
                end

                // read data back: collect byte, move to the next one
                S_MEM: begin
                    unique case (phase_reg)
                        PH_CMD: begin
                            rbyte_reg <= mem_rdata;
                            state_reg <= S_DONE;
                        end
                        PH_FETCH: begin
                            ins_reg[{idx_reg, 3'b000} +: 8] <= mem_rdata;
                            if (idx_reg == BYTE_LAST) begin
                                state_reg <= S_REGRD;
                            end else begin
                                idx_reg        <= idx_reg + 1'b1;
                                wrap_addr_reg  <= base_reg + {30'd0, idx_reg} + 32'd1;
                                wrap_start_reg <= 1'b1;
                                state_reg      <= S_WRAP;
                            end
                        end
                        PH_LOAD, PH_STORE: begin
                            wv_reg[{idx_reg, 3'b000} +: 8] <= mem_rdata;
                            if (idx_reg == last_reg) begin
                                state_reg <= S_FINISH;
                            end else begin
                                idx_reg        <= idx_reg + 1'b1;
                                wrap_addr_reg  <= base_reg + {30'd0, idx_reg} + 32'd1;
                                wrap_start_reg <= 1'b1;
                                state_reg      <= S_WRAP;
                            end
                        end
                    endcase
                end

                S_REGRD: begin
                    state_reg <= S_EXEC;
                end

                S_EXEC: begin
                    npc_reg   <= pc4;
                    wr_reg    <= 1'b0;
                    wv_reg    <= '0;
                    idx_reg   <= BYTE_FIRST;
                    last_reg  <= (f3 == F3_WORD) ? BYTE_LAST : BYTE_FIRST;
                    state_reg <= S_FINISH;
                    priority if (is_addi) begin
                        wr_reg <= 1'b1;
                        wv_reg <= sum_i;
                    end else if (is_jalr) begin
                        npc_reg <= {sum_i[31:1], 1'b0};
                        wr_reg  <= 1'b1;
                        wv_reg  <= pc4;
                    end else if (is_add) begin
                        wr_reg <= 1'b1;
                        wv_reg <= rs1v + rs2v;
                    end else if (is_lui) begin
                        wr_reg <= 1'b1;
                        wv_reg <= {ins_reg[31:12], 12'd0};
                    end else if (is_load) begin
                        wr_reg         <= 1'b1;
                        phase_reg      <= PH_LOAD;
                        base_reg       <= sum_i;
                        wrap_addr_reg  <= sum_i;
                        wrap_start_reg <= 1'b1;
                        state_reg      <= S_WRAP;
                    end else if (is_store) begin
                        phase_reg      <= PH_STORE;
                        store_reg      <= rs2v;
                        base_reg       <= sum_s;
                        wrap_addr_reg  <= sum_s;
                        wrap_start_reg <= 1'b1;
                        state_reg      <= S_WRAP;
                    end else if (is_halt_op) begin
                        halt_reg <= 1'b1;
                        npc_reg  <= epc_reg;
                    end else begin
                        // unknown encoding: plain pc advance
                        wr_reg <= 1'b0;
                    end
                end

                // register write-back and pc update
                S_FINISH: begin
                    if (rf_we) begin
                        rf_valid_reg[rd_idx] <= 1'b1;
                        dvalid_reg           <= 1'b1;
                        didx_reg             <= rd_idx;
                        dval_reg             <= wv_reg;
                    end
                    pc_reg    <= npc_reg;
                    state_reg <= S_DONE;
                end

                // hand the result to the output register once it is free
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, pc_reg, dval_reg, didx_reg, dvalid_reg,
                                         ins_reg, epc_reg, rbyte_reg, halt_reg};
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `RVSC_ASSERT_NEXT(a_halt_sticky, halt_reg, halt_reg, "halt flag dropped without reset")
    `RVSC_ASSERT_HOLDS(a_x0_not_written, 1'b1, !rf_valid_reg[0], "x0 marked as written")
    `RVSC_ASSERT_HOLDS(a_mem_on_wrap, mem_we || mem_re, state_reg == S_WRAP && wrap_done, "memory access without wrapped address")
    `RVSC_ASSERT_NEXT(a_pc_at_finish, state_reg != S_FINISH, $stable(pc_reg), "pc changed outside write-back")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rvsc_pkg::*;

    localparam int MEM_BYTES     = 1024;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 100;

    // Command code that the core answers but otherwise ignores
    localparam logic [1:0] CMD_NONE = 2'd3;
    // funct3 of jalr and of the system opcode
    localparam logic [2:0] F3_JALR  = 3'd0;
    localparam logic [2:0] F3_PRIV  = 3'd0;

    // One result beat, halted in the lowest bit
    typedef struct packed {
        logic [31:0] next_pc;
        logic [31:0] dest_value;
        logic [4:0]  dest_index;
        logic        dest_valid;
        logic [31:0] instruction;
        logic [31:0] executed_pc;
        logic [7:0]  read_byte;
        logic        halted;
    } step_result_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;

    int send_idle_pct = 23;
    int recv_idle_pct = 68;
    int mismatches    = 0;
    int results_seen  = 0;
    int beats_sent    = 0;
    int quiet_cycles  = 0;

    // Shadow state of the core
    logic [31:0] gpr [32];
    logic [7:0]  mem_image [MEM_BYTES];
    logic        loaded [MEM_BYTES];
    logic [31:0] pc_model;
    logic        halt_model;

    step_result_t results_due [$];

    rv32i_subset_core_top #(
        .MEM_BYTES(MEM_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Shadow model of the core
    // ------------------------------------------------------------------

    function automatic int wrap_index(logic [31:0] a);
        return int'(a % MEM_BYTES);
    endfunction

    function automatic logic [31:0] sext12(logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic logic [31:0] mem_word(logic [31:0] a);
        logic [31:0] w;
        for (int i = 0; i < 4; i++) w[8*i +: 8] = mem_image[wrap_index(a + i)];
        return w;
    endfunction

    function automatic bit all_loaded(logic [31:0] a, int n);
        for (int i = 0; i < n; i++) begin
            if (!loaded[wrap_index(a + i)]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic step_result_t core_step(logic [1:0] cmd, logic [9:0] addr,
                                               logic [7:0] data);
        step_result_t r;
        logic [31:0]  ins, rs1v, rs2v, npc, wv, ea;
        logic [6:0]   opc;
        logic [2:0]   f3;
        logic [4:0]   rd;
        logic         wr;
        int           nbytes;
        r = '0;
        case (cmd)
            CMD_WRITE: begin
                mem_image[wrap_index(addr)] = data;
                loaded[wrap_index(addr)]    = 1'b1;
            end
            CMD_READ: r.read_byte = mem_image[wrap_index(addr)];
            CMD_EXEC: begin
                r.executed_pc = pc_model;
                if (!halt_model) begin
                    ins  = mem_word(pc_model);
                    opc  = ins[6:0];
                    f3   = ins[14:12];
                    rd   = ins[11:7];
                    rs1v = gpr[ins[19:15]];
                    rs2v = gpr[ins[24:20]];
                    npc  = pc_model + 32'd4;
                    wr   = 1'b0;
                    wv   = '0;
                    if (opc == OP_IMM && f3 == F3_ADD) begin
                        wr = 1'b1;
                        wv = rs1v + sext12(ins[31:20]);
                    end else if (opc == OP_JALR && f3 == F3_JALR) begin
                        // target has bit 0 cleared, link is the old pc + 4
                        npc = (rs1v + sext12(ins[31:20])) & ~32'd1;
                        wr  = 1'b1;
                        wv  = pc_model + 32'd4;
                    end else if (opc == OP_REG && f3 == F3_ADD && ins[31:25] == F7_ADD) begin
                        wr = 1'b1;
                        wv = rs1v + rs2v;
                    end else if (opc == OP_LUI) begin
                        wr = 1'b1;
                        wv = {ins[31:12], 12'd0};
                    end else if (opc == OP_LOAD && f3 == F3_WORD) begin
                        wr = 1'b1;
                        wv = mem_word(rs1v + sext12(ins[31:20]));
                    end else if (opc == OP_LOAD && f3 == F3_BYTEU) begin
                        wr = 1'b1;
                        wv = {24'd0, mem_image[wrap_index(rs1v + sext12(ins[31:20]))]};
                    end else if (opc == OP_STORE && (f3 == F3_WORD || f3 == F3_BYTE)) begin
                        ea     = rs1v + sext12({ins[31:25], ins[11:7]});
                        nbytes = (f3 == F3_WORD) ? 4 : 1;
                        for (int i = 0; i < nbytes; i++) begin
                            mem_image[wrap_index(ea + i)] = rs2v[8*i +: 8];
                            loaded[wrap_index(ea + i)]    = 1'b1;
                        end
                    end else if (opc == OP_SYSTEM && f3 == F3_PRIV
                                 && ins[31:20] == F12_EBREAK) begin
                        halt_model = 1'b1;
                        npc        = pc_model;
                    end
                    // anything else falls through as a no-op
                    r.instruction = ins;
                    if (wr && rd != 5'd0) begin
                        gpr[rd]      = wv;
                        r.dest_valid = 1'b1;
                        r.dest_index = rd;
                        r.dest_value = wv;
                    end
                    pc_model = npc;
                end
            end
            default: ;
        endcase
        r.halted  = halt_model;
        r.next_pc = pc_model;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Instruction encoders
    // ------------------------------------------------------------------

    function automatic logic [31:0] enc_i(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
                                          logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                          logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [4:0] rd);
        return {f7, rs2, rs1, F3_ADD, rd, OP_REG};
    endfunction

    function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd);
        return {imm, rd, OP_LUI};
    endfunction

    // Words the core must treat as no-ops; never an ebreak, never a real load
    function automatic logic [31:0] unknown_encoding();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(6))
            0: begin
                w[6:0]   = OP_IMM;
                w[14:12] = 3'($urandom_range(7, 1));
            end
            1: begin
                w[6:0]   = OP_REG;
                w[31:25] = 7'($urandom_range(127, 1));
            end
            2: begin
                w[6:0] = OP_LOAD;
                do w[14:12] = 3'($urandom); while (w[14:12] == F3_WORD || w[14:12] == F3_BYTEU);
            end
            3: begin
                w[6:0] = OP_STORE;
                do w[14:12] = 3'($urandom); while (w[14:12] == F3_WORD || w[14:12] == F3_BYTE);
            end
            4: begin
                w[6:0]   = OP_JALR;
                w[14:12] = 3'($urandom_range(7, 1));
            end
            5: begin
                w[6:0] = OP_SYSTEM;
                do w[31:20] = 12'($urandom_range(3));
                while (w[14:12] == F3_PRIV && w[31:20] == F12_EBREAK);
            end
            default: begin
                do w[6:0] = 7'($urandom);
                while (w[6:0] inside {OP_IMM, OP_JALR, OP_REG, OP_LUI, OP_LOAD,
                                      OP_STORE, OP_SYSTEM});
            end
        endcase
        return w;
    endfunction

    // A word already in memory may be run again unless it halts or loads unwritten bytes
    function automatic bit safe_to_run(logic [31:0] ins);
        logic [31:0] ea;
        ea = gpr[ins[19:15]] + sext12(ins[31:20]);
        if (ins[6:0] == OP_SYSTEM && ins[14:12] == F3_PRIV && ins[31:20] == F12_EBREAK)
            return 1'b0;
        if (ins[6:0] == OP_LOAD && ins[14:12] == F3_WORD) return all_loaded(ea, 4);
        if (ins[6:0] == OP_LOAD && ins[14:12] == F3_BYTEU) return all_loaded(ea, 1);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Beat driver and helpers
    // ------------------------------------------------------------------

    task automatic send_beat(logic [1:0] cmd, logic [9:0] addr, logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, data, addr};
        do @(posedge aclk); while (!s_tready);
        results_due.push_back(core_step(cmd, addr, data));
        beats_sent++;
    endtask

    // Hold the input off until every outstanding result has been taken
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_due.size() != 0);
    endtask

    task automatic ensure_loaded(logic [31:0] a, int n);
        for (int i = 0; i < n; i++) begin
            if (!loaded[wrap_index(a + i)])
                send_beat(CMD_WRITE, 10'(wrap_index(a + i)), 8'($urandom));
        end
    endtask

    // Load the word at the current pc, then execute it
    task automatic run_instruction(logic [31:0] ins);
        for (int i = 0; i < 4; i++)
            send_beat(CMD_WRITE, 10'(wrap_index(pc_model + i)), ins[8*i +: 8]);
        send_beat(CMD_EXEC, 10'($urandom), 8'($urandom));
    endtask

    task automatic random_instruction();
        logic [4:0]  rd, rs1, rs2;
        logic [9:0]  target;
        logic [31:0] ins;
        logic        word;
        int          pick;
        rd   = 5'($urandom);
        rs1  = 5'($urandom);
        rs2  = 5'($urandom);
        pick = $urandom_range(99);
        if (pick < 14) begin
            ins = enc_i(OP_IMM, F3_ADD, rd, rs1, 12'($urandom));
        end else if (pick < 26) begin
            ins = enc_r(F7_ADD, rs2, rs1, rd);
        end else if (pick < 36) begin
            ins = enc_u(20'($urandom), rd);
        end else if (pick < 58) begin
            // aim the load at written bytes; any upper imm bits land there too
            word   = (pick < 48);
            target = 10'($urandom);
            ensure_loaded(target, word ? 4 : 1);
            ins = enc_i(OP_LOAD, word ? F3_WORD : F3_BYTEU, rd, rs1,
                        {2'($urandom), 10'(target - gpr[rs1][9:0])});
        end else if (pick < 76) begin
            ins = enc_s($urandom_range(1) ? F3_WORD : F3_BYTE, rs1, rs2, 12'($urandom));
        end else if (pick < 86) begin
            ins = enc_i(OP_JALR, F3_JALR, rd, rs1, 12'($urandom));
        end else begin
            ins = unknown_encoding();
        end
        run_instruction(ins);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_memory_port();
        send_beat(CMD_NONE, 10'h3FF, 8'hFF);
        send_beat(CMD_WRITE, 10'h155, 8'hAA);
        send_beat(CMD_WRITE, 10'h2AA, 8'h55);
        send_beat(CMD_READ, 10'h155, 8'h00);
        send_beat(CMD_READ, 10'h2AA, 8'hFF);
    endtask

    task automatic test_arithmetic();
        run_instruction(enc_u(20'h80000, 5'd1));                  // lui x1
        run_instruction(enc_i(OP_IMM, F3_ADD, 5'd2, 5'd1, 12'h800)); // most negative imm
        run_instruction(enc_r(F7_ADD, 5'd2, 5'd1, 5'd3));         // add x3
        run_instruction(enc_i(OP_IMM, F3_ADD, 5'd0, 5'd3, 12'h7FF)); // write to x0 dropped
    endtask

    task automatic test_loads_stores();
        run_instruction(enc_s(F3_WORD, 5'd0, 5'd3, 12'hFFE));     // word wraps past the top
        run_instruction(enc_i(OP_LOAD, F3_WORD, 5'd4, 5'd0, 12'h7FE));
        run_instruction(enc_s(F3_BYTE, 5'd0, 5'd2, 12'h7FF));
        run_instruction(enc_i(OP_LOAD, F3_BYTEU, 5'd5, 5'd0, 12'h800));
    endtask

    task automatic test_jump_and_unknown();
        // odd target, high address bits, fetch wraps through the top of memory
        run_instruction(enc_i(OP_JALR, F3_JALR, 5'd6, 5'd1, 12'h7FF));
        run_instruction(enc_r(7'h20, 5'd2, 5'd1, 5'd7));
    endtask

    task automatic test_random(int n);
        logic [9:0] a;
        int         first, pick, tries;
        first = beats_sent;
        while (beats_sent - first < n) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                if (all_loaded(pc_model, 4) && safe_to_run(mem_word(pc_model))
                    && $urandom_range(99) < 30)
                    send_beat(CMD_EXEC, 10'($urandom), 8'($urandom));
                else
                    random_instruction();
            end else if (pick < 84) begin
                send_beat(CMD_WRITE, 10'($urandom), 8'($urandom));
            end else if (pick < 95) begin
                a     = 10'($urandom);
                tries = 0;
                while (!loaded[wrap_index(a)] && tries < 16) begin
                    a = 10'($urandom);
                    tries++;
                end
                ensure_loaded(a, 1);
                send_beat(CMD_READ, a, 8'($urandom));
            end else if (pick < 98) begin
                send_beat(CMD_NONE, 10'($urandom), 8'($urandom));
            end else begin
                wait_for_results();
            end
        end
    endtask

    task automatic test_halt();
        run_instruction({F12_EBREAK, 5'($urandom), F3_PRIV, 5'($urandom), OP_SYSTEM});
        send_beat(CMD_EXEC, 10'($urandom), 8'($urandom));
        send_beat(CMD_WRITE, 10'h0F0, 8'h3C);
        send_beat(CMD_READ, 10'h0F0, 8'h00);
        send_beat(CMD_NONE, 10'h000, 8'h00);
        send_beat(CMD_EXEC, 10'($urandom), 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (got !== want)
            flag_error($sformatf("result %0d, %s: expected %h, got %h",
                                 results_seen, name, want, got));
    endtask

    always @(posedge aclk) begin
        step_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[142:0];
            if (results_due.size() == 0) begin
                flag_error($sformatf("result %0d arrived with nothing outstanding",
                                     results_seen));
            end else begin
                want = results_due.pop_front();
                check_field("halted",      want.halted,      got.halted);
                check_field("read_byte",   want.read_byte,   got.read_byte);
                check_field("executed_pc", want.executed_pc, got.executed_pc);
                check_field("instruction", want.instruction, got.instruction);
                check_field("dest_valid",  want.dest_valid,  got.dest_valid);
                check_field("dest_index",  want.dest_index,  got.dest_index);
                check_field("dest_value",  want.dest_value,  got.dest_value);
                check_field("next_pc",     want.next_pc,     got.next_pc);
            end
            results_seen++;
        end
    end

    // Watchdog: too long without a beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        for (int i = 0; i < 32; i++) gpr[i] = '0;
        for (int i = 0; i < MEM_BYTES; i++) begin
            mem_image[i] = '0;
            loaded[i]    = 1'b0;
        end
        pc_model   = '0;
        halt_model = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 23;
        recv_idle_pct = 68;
        test_memory_port();
        test_arithmetic();
        test_loads_stores();
        test_jump_and_unknown();
        test_random(300);
        wait_for_results();

        // the other way round
        send_idle_pct = 68;
        recv_idle_pct = 23;
        test_random(300);
        wait_for_results();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(300);
        test_halt();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
